### rtl/kcu_pkg.sv
// Shared types, constants and microcode ROM for the combination unranker.
// No dependencies; imported by the unranker top level and its port checker.
`default_nettype none

package kcu_pkg;

  localparam int MAX_COUNT = 32;
  localparam int TAB_ROWS  = 2 * MAX_COUNT;
  localparam int TAB_COLS  = MAX_COUNT + 1;
  localparam int TAB_DEPTH = TAB_ROWS * TAB_COLS;

  localparam int CNT_W  = 6;
  localparam int RANK_W = 30;
  localparam int ROW_W  = $clog2(TAB_ROWS);
  localparam int COL_W  = $clog2(TAB_COLS);
  localparam int ADDR_W = $clog2(TAB_DEPTH);

  localparam logic [RANK_W-1:0] BINOM_CAP = RANK_W'(1000 * 1000 * 1000);

  localparam logic SYM_DASH = 1'b0;
  localparam logic SYM_DOT  = 1'b1;

  // Micro-op performed by a step when its jump is not taken
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_RDTAB,
    OP_DECIDE,
    OP_EMIT_DASH,
    OP_EMIT_DOT,
    OP_EMIT_EMPTY
  } uop_t;

  // Jump condition tested at each step
  typedef enum logic [2:0] {
    C_NEVER,
    C_EMPTY,
    C_LOOP_DONE,
    C_DASH_ZERO,
    C_DOT_ZERO
  } ucond_t;

  localparam int UPC_W = 3;

  localparam logic [UPC_W-1:0] UPC_IDLE  = 3'd0;
  localparam logic [UPC_W-1:0] UPC_CHECK = 3'd1;
  localparam logic [UPC_W-1:0] UPC_READ  = 3'd2;
  localparam logic [UPC_W-1:0] UPC_PICK  = 3'd3;
  localparam logic [UPC_W-1:0] UPC_DASHS = 3'd4;
  localparam logic [UPC_W-1:0] UPC_DOTS  = 3'd5;
  localparam logic [UPC_W-1:0] UPC_EMPTY = 3'd6;

  typedef struct packed {
    uop_t             op;
    ucond_t           cond;
    logic [UPC_W-1:0] jump;
    logic [UPC_W-1:0] fall;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    case (upc)
      UPC_IDLE:  w = '{OP_LOAD,       C_NEVER,     UPC_IDLE,  UPC_CHECK};
      UPC_CHECK: w = '{OP_NOP,        C_EMPTY,     UPC_EMPTY, UPC_READ};
      UPC_READ:  w = '{OP_RDTAB,      C_LOOP_DONE, UPC_DASHS, UPC_PICK};
      UPC_PICK:  w = '{OP_DECIDE,     C_NEVER,     UPC_READ,  UPC_READ};
      UPC_DASHS: w = '{OP_EMIT_DASH,  C_DASH_ZERO, UPC_DOTS,  UPC_DASHS};
      UPC_DOTS:  w = '{OP_EMIT_DOT,   C_DOT_ZERO,  UPC_IDLE,  UPC_DOTS};
      UPC_EMPTY: w = '{OP_EMIT_EMPTY, C_NEVER,     UPC_IDLE,  UPC_IDLE};
      default:   w = '{OP_NOP,        C_NEVER,     UPC_IDLE,  UPC_IDLE};
    endcase
    return w;
  endfunction

  // Flat address of binomial entry [row][col]
  function automatic logic [ADDR_W-1:0] tab_addr(input logic [ROW_W-1:0] row,
                                                 input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(TAB_COLS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

### rtl/kth_combination_unranker.sv
// Top level of the constant-weight word unranker: table fill, microcoded decode.
// Depends on kcu_pkg (constants, micro-op types, microcode ROM).
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid/in_ready, in_num_dashes,        | input item
//          | in_num_dots, in_rank                     |
//  out     | out_valid/out_ready, out_symbol,         | one symbol per item
//          | out_last, out_empty_res                  |
//
// After reset the binomial memory is built by a sweep over all TAB_DEPTH
// entries; in_ready stays low until it ends.
// One word at a time: while the rank picks symbols, each needs one memory read,
// then compare and subtract; tail symbols need no read. A word has at most 64
// symbols. A stalled output register holds the sequencer at any step that
// would write to it.
`default_nettype none

module kth_combination_unranker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [kcu_pkg::CNT_W-1:0]  in_num_dashes,
  input  logic [kcu_pkg::CNT_W-1:0]  in_num_dots,
  input  logic [kcu_pkg::RANK_W-1:0] in_rank,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_symbol,
  output logic                       out_last,
  output logic                       out_empty_res
);
  import kcu_pkg::*;

  // ---------------- binomial memory ----------------
  logic [RANK_W-1:0] tab_mem [TAB_DEPTH];
  logic [RANK_W-1:0] tab_rd_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [RANK_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_mem[wr_addr] <= wr_data;
    end
    tab_rd_r <= tab_mem[rd_addr];
  end

  // ---------------- fill sweep ----------------
  logic              ini_busy_r;
  logic [ROW_W-1:0]  ini_row_r;
  logic [COL_W-1:0]  ini_col_r;
  logic              wb_vld_r;
  logic [ROW_W-1:0]  wb_row_r;
  logic [COL_W-1:0]  wb_col_r;
  logic [RANK_W-1:0] prev_r;
  logic              init_done_r;
  logic [RANK_W:0]   pas_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ini_busy_r  <= 1'b1;
      ini_row_r   <= '0;
      ini_col_r   <= '0;
      wb_vld_r    <= 1'b0;
      wb_row_r    <= '0;
      wb_col_r    <= '0;
      init_done_r <= 1'b0;
    end else begin
      wb_vld_r <= ini_busy_r;
      wb_row_r <= ini_row_r;
      wb_col_r <= ini_col_r;
      if (ini_busy_r) begin
        if (ini_col_r == COL_W'(TAB_COLS - 1)) begin
          ini_col_r <= '0;
          ini_row_r <= ini_row_r + 1'b1;
          if (ini_row_r == ROW_W'(TAB_ROWS - 1)) begin
            ini_busy_r <= 1'b0;
          end
        end else begin
          ini_col_r <= ini_col_r + 1'b1;
        end
      end
      if (wb_vld_r && !ini_busy_r) begin
        init_done_r <= 1'b1;
      end
    end
  end

  // prev_r carries entry [row-1][col-1] along the row
  always_ff @(posedge clk) begin
    if (wb_vld_r) begin
      prev_r <= (wb_col_r == '0) ? RANK_W'(1) : tab_rd_r;
    end
  end

  assign pas_sum = {1'b0, prev_r} + {1'b0, tab_rd_r};
  assign wr_en   = wb_vld_r;
  assign wr_addr = tab_addr(wb_row_r, wb_col_r);

  always_comb begin
    if (wb_col_r == '0) begin
      wr_data = RANK_W'(1);
    end else if (wb_row_r == '0) begin
      wr_data = '0;
    end else if (pas_sum >= {1'b0, BINOM_CAP}) begin
      wr_data = BINOM_CAP;
    end else begin
      wr_data = pas_sum[RANK_W-1:0];
    end
  end

  // ---------------- microcoded decode ----------------
  logic [UPC_W-1:0]  upc_r, upc_nxt;
  logic [CNT_W-1:0]  dashes_r, dashes_nxt;
  logic [CNT_W-1:0]  dots_r, dots_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_symbol_r, out_symbol_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;

  uword_t            uw;
  logic              cond_hit;
  logic              blocked;
  logic              exec;
  logic              out_free;
  logic              go_dot;
  logic [ROW_W-1:0]  dec_row;
  logic [CNT_W:0]    len;

  assign uw       = ucode_rom(upc_r);
  assign out_free = !out_valid_r || out_ready;
  assign len      = {1'b0, dashes_r} + {1'b0, dots_r};
  assign dec_row  = ROW_W'(len - 1'b1);
  assign go_dot   = tab_rd_r < rank_r;
  assign rd_addr  = ini_busy_r ? tab_addr(ini_row_r - 1'b1, ini_col_r)
                               : tab_addr(dec_row, dots_r[COL_W-1:0]);

  always_comb begin
    case (uw.cond)
      C_NEVER:     cond_hit = 1'b0;
      C_EMPTY:     cond_hit = (dashes_r == '0) && (dots_r == '0);
      C_LOOP_DONE: cond_hit = (dashes_r == '0) || (dots_r == '0) || (rank_r == '0);
      C_DASH_ZERO: cond_hit = (dashes_r == '0);
      C_DOT_ZERO:  cond_hit = (dots_r == '0);
      default:     cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (uw.op)
      OP_LOAD:       blocked = !in_valid || !init_done_r;
      OP_DECIDE,
      OP_EMIT_DASH,
      OP_EMIT_DOT,
      OP_EMIT_EMPTY: blocked = !out_free;
      default:       blocked = 1'b0;
    endcase
  end

  assign exec     = !cond_hit && !blocked;
  assign in_ready = (uw.op == OP_LOAD) && init_done_r;

  always_comb begin
    dashes_nxt     = dashes_r;
    dots_nxt       = dots_r;
    rank_nxt       = rank_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;

    if (cond_hit) begin
      upc_nxt = uw.jump;
    end else if (exec) begin
      upc_nxt = uw.fall;
    end else begin
      upc_nxt = upc_r;
    end

    if (exec) begin
      case (uw.op)
        OP_LOAD: begin
          // clamp counts to the table size
          dashes_nxt = (in_num_dashes > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
                                                           : in_num_dashes;
          dots_nxt   = (in_num_dots > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT)
                                                         : in_num_dots;
          rank_nxt   = in_rank;
        end
        OP_DECIDE: begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = go_dot ? SYM_DOT : SYM_DASH;
          out_last_nxt   = 1'b0;
          out_empty_nxt  = 1'b0;
          if (go_dot) begin
            rank_nxt = rank_r - tab_rd_r;
            dots_nxt = dots_r - 1'b1;
          end else begin
            dashes_nxt = dashes_r - 1'b1;
          end
        end
        OP_EMIT_DASH: begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = SYM_DASH;
          out_last_nxt   = (dashes_r == CNT_W'(1)) && (dots_r == '0);
          out_empty_nxt  = 1'b0;
          dashes_nxt     = dashes_r - 1'b1;
        end
        OP_EMIT_DOT: begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = SYM_DOT;
          out_last_nxt   = (dots_r == CNT_W'(1));
          out_empty_nxt  = 1'b0;
          dots_nxt       = dots_r - 1'b1;
        end
        OP_EMIT_EMPTY: begin
          out_valid_nxt  = 1'b1;
          out_symbol_nxt = SYM_DASH;
          out_last_nxt   = 1'b1;
          out_empty_nxt  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= UPC_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      upc_r        <= upc_nxt;
      out_valid_r  <= out_valid_nxt;
      dashes_r     <= dashes_nxt;
      dots_r       <= dots_nxt;
      rank_r       <= rank_nxt;
      out_symbol_r <= out_symbol_nxt;
      out_last_r   <= out_last_nxt;
      out_empty_r  <= out_empty_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_symbol    = out_symbol_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;

endmodule

`default_nettype wire

### rtl/kcu_checker.sv
// Port-level checks for the combination unranker, bound to its top level.
// Depends on kcu_pkg for port widths and on kth_combination_unranker.
`default_nettype none

module kcu_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [kcu_pkg::CNT_W-1:0]  in_num_dashes,
  input logic [kcu_pkg::CNT_W-1:0]  in_num_dots,
  input logic [kcu_pkg::RANK_W-1:0] in_rank,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       out_symbol,
  input logic                       out_last,
  input logic                       out_empty_res
);
  import kcu_pkg::*;

  // a waiting input item holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_num_dashes) &&
      $stable(in_num_dots) && $stable(in_rank))
    else $error("input item changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) &&
      $stable(out_last) && $stable(out_empty_res))
    else $error("result item changed while stalled");

  // the empty marker is a single dash-coded item that closes the word
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last && (out_symbol == SYM_DASH))
    else $error("empty item not marked last or not a dash");

  // one word at a time: no new item right after one is taken
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // a word in flight blocks input while a non-last symbol is on the output
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("input ready while a word is still being emitted");

endmodule

bind kth_combination_unranker kcu_checker u_kcu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_num_dashes (in_num_dashes),
  .in_num_dots   (in_num_dots),
  .in_rank       (in_rank),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_symbol    (out_symbol),
  .out_last      (out_last),
  .out_empty_res (out_empty_res)
);

`default_nettype wire
